>>> rtl/iev_pkg.sv
`timescale 1ns / 1ps
package iev_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int NUM_KEYS        = 128;
  localparam int NUM_MODS        = 5;

  localparam logic [2:0] OP_KEY      = 3'd0;
  localparam logic [2:0] OP_BUTTON   = 3'd1;
  localparam logic [2:0] OP_POS      = 3'd2;
  localparam logic [2:0] OP_POP_KEY  = 3'd3;
  localparam logic [2:0] OP_POP_ANY  = 3'd4;
  localparam logic [2:0] OP_RELEASE  = 3'd5;
  localparam logic [2:0] OP_RECOVER  = 3'd6;
  localparam logic [2:0] OP_CLEAR    = 3'd7;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_KEY    = 2'd1;
  localparam logic [1:0] KIND_BUTTON = 2'd2;
  localparam logic [1:0] KIND_POS    = 2'd3;

  localparam logic [2:0] CFG_COMMAND  = 3'd0;
  localparam logic [2:0] CFG_SHIFT    = 3'd1;
  localparam logic [2:0] CFG_CAPSLOCK = 3'd2;
  localparam logic [2:0] CFG_OPTION   = 3'd3;
  localparam logic [2:0] CFG_CONTROL  = 3'd4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [6:0]  key_code;
    logic        pressed;
    logic [15:0] pos_h;
    logic [15:0] pos_v;
    logic [4:0]  keep_mask;
  } in_t;

  typedef struct packed {
    logic        done_res;
    logic [1:0]  ev_kind;
    logic [6:0]  ev_key;
    logic        ev_down;
    logic [15:0] ev_h;
    logic [15:0] ev_v;
    logic        overflow;
    logic [4:0]  fill;
  } out_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  key;
    logic        down;
    logic [15:0] h;
    logic [15:0] v;
  } entry_t;

  typedef struct packed {
    in_t  item;
    logic needs_read;
    logic needs_walk;
  } cmd_t;

endpackage

>>> rtl/input_event_queue.sv
`timescale 1ns / 1ps
// Input event queue. An operation is taken when start is high and busy is low; a
// two-entry command queue buffers operations while the event engine works. Each
// operation yields exactly one result on out_data, marked by out_strobe for one
// cycle, which the receiver must take. Key, button, position and clear-keys go
// straight to the result state; pops pass through a pop state first for the
// registered read of the event memory (skipped on an empty queue), and release-all
// and recover through a walk over all 128 keys at one key a cycle.
module input_event_queue import iev_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_t        in_data,
  output logic       out_strobe,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_idx,
  input  logic [6:0] cfg_wdata
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  iev_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  iev_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

>>> rtl/iev_front.sv
`timescale 1ns / 1ps
module iev_front import iev_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic cmd_valid,
  output cmd_t cmd,
  input  logic cmd_pop
);

  cmd_t       q_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;
  logic       push;
  cmd_t       cls;

  always_comb begin
    cls.item       = in_data;
    cls.needs_read = (in_data.operation == OP_POP_KEY) || (in_data.operation == OP_POP_ANY);
    cls.needs_walk = (in_data.operation == OP_RELEASE) || (in_data.operation == OP_RECOVER);
  end

  assign busy      = (cnt_r == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (cmd_pop) begin
        rptr_r <= !rptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

>>> rtl/iev_back.sv
`timescale 1ns / 1ps
module iev_back import iev_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  input  logic       cfg_we,
  input  logic [2:0] cfg_idx,
  input  logic [6:0] cfg_wdata,
  output logic       out_strobe,
  output out_t       out_data
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_POP, S_WALK, S_RESP} state_t;

  entry_t                mem [QUEUE_DEPTH];
  entry_t                rdata_r;
  state_t                state_r;
  logic [AW-1:0]         wr_ptr_r;
  logic [AW-1:0]         rd_ptr_r;
  logic [AW-1:0]         last_ptr_r;
  logic [FW-1:0]         fill_r;
  logic [NUM_KEYS-1:0]   key_map_r;
  logic                  button_r;
  logic [15:0]           last_h_r;
  logic [15:0]           last_v_r;
  logic                  lost_r;
  logic                  newest_pos_r;
  logic [6:0]            mod_r [NUM_MODS];
  logic [6:0]            k_r;
  logic [4:0]            keep_r;
  logic                  any_r;
  logic [2:0]            op_r;
  logic                  done_r;
  entry_t                ev_r;

  logic          not_full;
  logic          we;
  logic          push;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic          kept;
  logic          walk_hit;
  logic [8:0]    fill_ext;
  in_t           it;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign it       = cmd.item;
  assign not_full = (fill_r < FW'(QUEUE_DEPTH));
  assign cmd_pop  = (state_r == S_IDLE) && cmd_valid;

  always_comb begin
    kept = 1'b0;
    for (int i = 0; i < NUM_MODS; i++) begin
      if ((mod_r[i] == k_r) && keep_r[i]) begin
        kept = 1'b1;
      end
    end
  end

  assign walk_hit = key_map_r[k_r] && !kept;

  always_comb begin
    we    = 1'b0;
    push  = 1'b0;
    waddr = wr_ptr_r;
    wdata = '0;
    if (cmd_pop) begin
      unique case (it.operation)
        OP_KEY: begin
          wdata.kind = KIND_KEY;
          wdata.key  = it.key_code;
          wdata.down = it.pressed;
          push = (key_map_r[it.key_code] != it.pressed) && not_full;
        end
        OP_BUTTON: begin
          wdata.kind = KIND_BUTTON;
          wdata.down = it.pressed;
          push = (button_r != it.pressed) && not_full;
        end
        OP_RECOVER: begin
          wdata.kind = KIND_BUTTON;
          push = button_r && not_full;
        end
        OP_POS: begin
          wdata.kind = KIND_POS;
          wdata.h    = it.pos_h;
          wdata.v    = it.pos_v;
          if ((it.pos_h != last_h_r) || (it.pos_v != last_v_r)) begin
            if ((fill_r != '0) && newest_pos_r) begin
              we    = 1'b1;
              waddr = last_ptr_r;
            end else begin
              push = not_full;
            end
          end
        end
        default: ;
      endcase
    end else if (state_r == S_WALK) begin
      wdata.kind = KIND_KEY;
      wdata.key  = k_r;
      push = walk_hit && not_full;
    end
    we = we || push;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      last_ptr_r   <= '0;
      fill_r       <= '0;
      key_map_r    <= '0;
      button_r     <= 1'b0;
      last_h_r     <= '0;
      last_v_r     <= '0;
      lost_r       <= 1'b0;
      newest_pos_r <= 1'b0;
      mod_r[0]     <= 7'd55;
      mod_r[1]     <= 7'd56;
      mod_r[2]     <= 7'd57;
      mod_r[3]     <= 7'd58;
      mod_r[4]     <= 7'd59;
      k_r          <= '0;
      keep_r       <= '0;
      any_r        <= 1'b0;
      op_r         <= OP_KEY;
      done_r       <= 1'b0;
      ev_r         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_COMMAND:  mod_r[0] <= cfg_wdata;
          CFG_SHIFT:    mod_r[1] <= cfg_wdata;
          CFG_CAPSLOCK: mod_r[2] <= cfg_wdata;
          CFG_OPTION:   mod_r[3] <= cfg_wdata;
          CFG_CONTROL:  mod_r[4] <= cfg_wdata;
          default: ;
        endcase
      end
      if (we) begin
        newest_pos_r <= (wdata.kind == KIND_POS);
      end
      if (push) begin
        wr_ptr_r   <= ptr_inc(wr_ptr_r);
        last_ptr_r <= wr_ptr_r;
        fill_r     <= fill_r + 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd_pop) begin
            done_r <= 1'b0;
            ev_r   <= '0;
            op_r   <= it.operation;
            state_r <= S_RESP;
            if (cmd.needs_read) begin
              if (fill_r != '0) begin
                state_r <= S_POP;
              end
            end else if (cmd.needs_walk) begin
              k_r     <= '0;
              state_r <= S_WALK;
              if (it.operation == OP_RECOVER) begin
                keep_r <= '0;
                any_r  <= push;
                lost_r <= button_r && !not_full;
                if (push) begin
                  button_r <= 1'b0;
                end
              end else begin
                keep_r <= it.keep_mask;
                any_r  <= 1'b0;
              end
            end else begin
              unique case (it.operation)
                OP_KEY: begin
                  if (key_map_r[it.key_code] != it.pressed) begin
                    if (push) begin
                      key_map_r[it.key_code] <= it.pressed;
                      done_r <= 1'b1;
                    end else begin
                      lost_r <= 1'b1;
                    end
                  end
                end
                OP_BUTTON: begin
                  if (button_r != it.pressed) begin
                    if (push) begin
                      button_r <= it.pressed;
                      done_r   <= 1'b1;
                    end else begin
                      lost_r <= 1'b1;
                    end
                  end
                end
                OP_POS: begin
                  if ((it.pos_h != last_h_r) || (it.pos_v != last_v_r)) begin
                    if (we) begin
                      last_h_r <= it.pos_h;
                      last_v_r <= it.pos_v;
                      done_r   <= 1'b1;
                    end else begin
                      lost_r <= 1'b1;
                    end
                  end
                end
                OP_CLEAR: key_map_r <= '0;
                default: ;
              endcase
            end
          end
        end
        S_POP: begin
          if ((op_r == OP_POP_ANY) || (rdata_r.kind == KIND_KEY)) begin
            ev_r     <= rdata_r;
            rd_ptr_r <= ptr_inc(rd_ptr_r);
            fill_r   <= fill_r - 1'b1;
            done_r   <= 1'b1;
          end
          state_r <= S_RESP;
        end
        S_WALK: begin
          if (walk_hit) begin
            if (not_full) begin
              key_map_r[k_r] <= 1'b0;
              any_r <= 1'b1;
            end else begin
              lost_r <= 1'b1;
            end
          end
          if (k_r == 7'(NUM_KEYS - 1)) begin
            done_r  <= any_r || push;
            state_r <= S_RESP;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_RESP: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign fill_ext   = 9'(fill_r);
  assign out_strobe = (state_r == S_RESP);

  always_comb begin
    out_data.done_res = done_r;
    out_data.ev_kind  = ev_r.kind;
    out_data.ev_key   = ev_r.key;
    out_data.ev_down  = ev_r.down;
    out_data.ev_h     = ev_r.h;
    out_data.ev_v     = ev_r.v;
    out_data.overflow = lost_r;
    out_data.fill     = fill_ext[4:0];
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(QUEUE_DEPTH))
    else $error("fill above queue depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full)
    else $error("entry queued into a full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> (fill_r != '0))
    else $error("pop from an empty queue");

  a_resp_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result held longer than one cycle");
`endif

endmodule
